// ----- rtl/core/svdec_pkg.sv -----
// Shared types, codes and a helper function of the six-bit stream value decoder.
`timescale 1ns / 1ps

package svdec_pkg;

   // Default bound on the number of longs in one array
   localparam int unsigned DEF_MAX_ARRAY_LONGS = 65536;

   // Expected value kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_SHORT = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;
   localparam logic [1:0] KIND_ARRAY = 2'd3;

   // Result status codes
   localparam logic [2:0] STATUS_SCALAR    = 3'd0;
   localparam logic [2:0] STATUS_ELEMENT   = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_SYNC_ERR  = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

   // Register indexes of the control port
   localparam logic [1:0] CSR_FAST_MODE     = 2'd0;
   localparam logic [1:0] CSR_SYNC_CHAR     = 2'd1;
   localparam logic [1:0] CSR_FILTER_ENABLE = 2'd2;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SCALAR,
      PH_LEN,
      PH_SYNC,
      PH_ELEM
   } phase_type;

   // One received character and the kind of value it belongs to
   typedef struct packed {
      logic [7:0] rx_char;
      logic [1:0] value_kind;
   } req_type;

   // One decoded result
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // Control register contents
   typedef struct packed {
      logic       fast_mode;
      logic [6:0] sync_char;
      logic       filter_enable;
   } cfg_type;

   // Number of characters that make up a value of the given kind
   function automatic logic [2:0] digits_needed(input logic [1:0] kind, input logic fast);
      logic [2:0] n;
      begin
         case (kind)
            KIND_BYTE:  n = fast ? 3'd1 : 3'd2;
            KIND_SHORT: n = fast ? 3'd2 : 3'd3;
            default:    n = fast ? 3'd4 : 3'd6;
         endcase
         return n;
      end
   endfunction

endpackage

// ----- rtl/core/svdec_in_stage.sv -----
// Input register stage: captures one request and holds it until the decoder takes it.
`timescale 1ns / 1ps

module svdec_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  svdec_pkg::req_type req_data,
   input  logic              advance,
   output logic              item_valid,
   output svdec_pkg::req_type item
);
   import svdec_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   req_type data_in;

   // Hold the request while the decoder cannot take it
   assign req_stall = valid_ff && !advance;

   // Load a new request whenever the stage is free or being emptied
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// ----- rtl/core/svdec_decode.sv -----
// Decoder state and the single-pass logic that folds one character into the value.
`timescale 1ns / 1ps

module svdec_decode #(
   parameter int unsigned MAX_ARRAY_LONGS = svdec_pkg::DEF_MAX_ARRAY_LONGS
) (
   input  logic               clock,
   input  logic               reset,
   input  svdec_pkg::cfg_type cfg,
   input  logic               fire,
   input  svdec_pkg::req_type item,
   output logic               res_valid,
   output svdec_pkg::rsp_type res
);
   import svdec_pkg::*;

   localparam int unsigned RW = $clog2(MAX_ARRAY_LONGS + 1);
   localparam logic [29:0] MAX_LONGS = 30'(MAX_ARRAY_LONGS);

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  kind_ff, kind_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [2:0]  idx_ff, idx_in;

   logic [6:0]  c7;
   logic        fast;
   logic        sync_ok;
   logic        dropped;
   logic        start;
   phase_type   eff_phase;
   logic [1:0]  eff_kind;
   logic [31:0] acc_base;
   logic [2:0]  cnt_base;
   logic [5:0]  digit;
   logic [5:0]  sh;
   logic [31:0] acc_new;
   logic [2:0]  cnt_new;
   logic [2:0]  need;
   logic        complete;
   logic        empty;
   logic [31:0] len_sum;
   logic [29:0] nlongs;
   logic        too_long;
   logic [RW-1:0] rem_new;
   logic [2:0]  idx_new;
   logic        done;
   logic [31:0] scalar_val;

   // Keep only printable characters and four control codes
   function automatic logic char_ok(input logic [6:0] k);
      begin
         return (k >= 7'h20 && k <= 7'h7e) || k == 7'h03 || k == 7'h0a ||
                k == 7'h0d || k == 7'h12;
      end
   endfunction

   assign c7       = item.rx_char[6:0];
   assign fast     = cfg.fast_mode;
   assign sync_ok  = (c7 == cfg.sync_char);
   assign dropped  = !fast && cfg.filter_enable && !char_ok(c7);
   assign start    = (phase_ff == PH_IDLE);
   assign eff_phase = start ? ((item.value_kind == KIND_ARRAY) ? PH_LEN : PH_SCALAR)
                            : phase_ff;
   assign eff_kind = start ? item.value_kind : kind_ff;
   assign acc_base = start ? 32'd0 : acc_ff;
   assign cnt_base = start ? 3'd0 : cnt_ff;

   // Shift in one six-bit group at its place, or one raw byte from the bottom
   assign digit   = c7[5:0] - 6'h20;
   assign sh      = 6'({cnt_base, 2'b00}) + 6'({cnt_base, 1'b0});
   assign acc_new = fast ? {acc_base[23:0], item.rx_char}
                         : (acc_base | ({26'd0, digit} << sh));
   assign cnt_new = cnt_base + 3'd1;
   assign need    = digits_needed((eff_phase == PH_SCALAR) ? eff_kind : KIND_LONG, fast);
   assign complete = (cnt_new >= need);

   // Array length checks
   assign empty    = (acc_new == 32'd0) || acc_new[31];
   assign len_sum  = {1'b0, acc_new[30:0]} + 32'd3;
   assign nlongs   = len_sum[31:2];
   assign too_long = (nlongs > MAX_LONGS);

   // Element bookkeeping
   assign rem_new = rem_ff - RW'(1);
   assign idx_new = idx_ff + 3'd1;
   assign done    = (rem_new == '0);

   // Trim scalars to their width
   always_comb begin
      case (eff_kind)
         KIND_BYTE:  scalar_val = {24'd0, acc_new[7:0]};
         KIND_SHORT: scalar_val = {16'd0, acc_new[15:0]};
         default:    scalar_val = acc_new;
      endcase
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (phase_ff == PH_SYNC) begin
            phase_in = sync_ok ? PH_ELEM : PH_IDLE;
         end else if (!dropped) begin
            if (!complete) begin
               phase_in = eff_phase;
            end else begin
               case (eff_phase)
                  PH_LEN:  phase_in = (empty || too_long) ? PH_IDLE : PH_SYNC;
                  PH_ELEM: phase_in = done ? PH_IDLE :
                                      ((idx_new == 3'd0) ? PH_SYNC : PH_ELEM);
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   // Datapath updates and the result
   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      res_valid = 1'b0;
      res       = '{value: 32'd0, status: STATUS_SCALAR, last: 1'b1};
      if (fire) begin
         if (phase_ff == PH_SYNC) begin
            acc_in = 32'd0;
            cnt_in = 3'd0;
            if (!sync_ok) begin
               rem_in    = '0;
               idx_in    = 3'd0;
               res_valid = 1'b1;
               res       = '{value: 32'd0, status: STATUS_SYNC_ERR, last: 1'b1};
            end
         end else if (!dropped) begin
            kind_in = eff_kind;
            if (!complete) begin
               acc_in = acc_new;
               cnt_in = cnt_new;
            end else begin
               acc_in = 32'd0;
               cnt_in = 3'd0;
               case (eff_phase)
                  PH_LEN: begin
                     if (empty) begin
                        res_valid = 1'b1;
                        res = '{value: 32'd0, status: STATUS_EMPTY, last: 1'b1};
                     end else if (too_long) begin
                        res_valid = 1'b1;
                        res = '{value: acc_new, status: STATUS_TOO_LONG, last: 1'b1};
                     end else begin
                        rem_in = nlongs[RW-1:0];
                        idx_in = 3'd0;
                     end
                  end
                  PH_ELEM: begin
                     rem_in    = rem_new;
                     idx_in    = idx_new;
                     res_valid = 1'b1;
                     res = '{value: acc_new, status: STATUS_ELEMENT, last: done};
                  end
                  default: begin
                     res_valid = 1'b1;
                     res = '{value: scalar_val, status: STATUS_SCALAR, last: 1'b1};
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= 32'd0;
         cnt_ff   <= 3'd0;
         kind_ff  <= 2'd0;
         rem_ff   <= '0;
         idx_ff   <= 3'd0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         kind_ff  <= kind_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- rtl/core/svdec_out_q.sv -----
// Two-entry result register with a skid entry, so the decoder keeps running under a short stall.
`timescale 1ns / 1ps

module svdec_out_q (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  svdec_pkg::rsp_type push_data,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output svdec_pkg::rsp_type rsp_data
);
   import svdec_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    skid_ff, skid_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;

   // Advance the head, park a result in the skid entry when the head is held
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               skid_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- rtl/core/six_bit_stream_value_decoder_core.sv -----
// Top level of the six-bit stream value decoder: control registers and datapath wiring.
`timescale 1ns / 1ps

// Decodes a character stream into byte, short, long and array values. One
// request is taken every cycle while the result queue is not full; the
// request that completes a value is held in the input register and its
// result in the result register before it appears on the rsp side. Work
// per character is a single shift-or and counter update, so the rate is
// set only by the result queue: two entries deep, it absorbs the result
// decoded during a result stall, and requests then stall while it drains
// back to one entry. Requests stall whenever both entries are held and the
// input register holds a request. Control registers are written through
// the csr port, which never stalls, and must only be changed while no value is in progress.
module six_bit_stream_value_decoder_core #(
   parameter int unsigned MAX_ARRAY_LONGS = svdec_pkg::DEF_MAX_ARRAY_LONGS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  svdec_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output svdec_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_data
);
   import svdec_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    item_valid;
   req_type item;
   logic    q_full;
   logic    fire;
   logic    res_valid;
   rsp_type res;

   assign csr_ready = 1'b1;

   // Update the addressed control register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAST_MODE:     cfg_in.fast_mode     = csr_data[0];
            CSR_SYNC_CHAR:     cfg_in.sync_char     = csr_data;
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode the held request whenever the result queue has room
   assign fire = item_valid && !q_full;

   svdec_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (!q_full),
      .item_valid (item_valid),
      .item       (item)
   );

   svdec_decode #(
      .MAX_ARRAY_LONGS (MAX_ARRAY_LONGS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   svdec_out_q u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
